// ===== hw/rtl/vpr_pkg.sv =====
`default_nettype none

package vpr_pkg;

  // fixed-point format of one vector component
  localparam int FRAC_BITS  = 16;
  localparam int COMP_WIDTH = 32;

  // unsigned magnitude of a four-term dot product
  localparam int DOT_W   = 2 * COMP_WIDTH + 1;
  // square root radicand and root widths
  localparam int SQ_IN_W = DOT_W + 2 * FRAC_BITS;
  localparam int SQ_W    = (SQ_IN_W + 1) / 2;
  // magnitude of a component times a dot product, and of their difference
  localparam int MAG_W   = 3 * COMP_WIDTH + 1;
  // normalize numerator width
  localparam int NRM_W   = COMP_WIDTH + 2 * FRAC_BITS;
  localparam int NUM_W   = (MAG_W > NRM_W) ? MAG_W : NRM_W;
  localparam int DIV_W   = DOT_W;
  localparam int REM_W   = ((NUM_W > DIV_W + COMP_WIDTH) ? NUM_W : DIV_W + COMP_WIDTH) + 1;
  // dot products are split into three slices for the wide multiplies
  localparam int CHUNK_W = (DOT_W + 2) / 3;
  // latency from an accepted request to its result strobe
  localparam int LATENCY = SQ_W + COMP_WIDTH + 10;

  typedef enum logic [1:0] {
    ACT_PROJECT   = 2'd0,
    ACT_REJECT    = 2'd1,
    ACT_NORMALIZE = 2'd2
  } act_t;

  typedef logic [COMP_WIDTH-1:0] comp_t;

  // request context carried alongside the square root pipeline
  typedef struct packed {
    logic [1:0]       act;
    comp_t [3:0]      a;
    comp_t [3:0]      b;
    logic [DOT_W:0]   dab;
    logic [DOT_W-1:0] dbb;
  } item_t;

  // sideband carried alongside the divider pipeline
  typedef struct packed {
    logic [1:0] act;
    logic       deg;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vpr_isqrt.sv =====
`default_nettype none

module vpr_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  vpr_pkg::item_t              in_item,
  output logic                        out_vld,
  output vpr_pkg::item_t              out_item,
  output logic [vpr_pkg::SQ_W-1:0]    out_root
);

  localparam int SW = vpr_pkg::SQ_W;
  localparam int RW = SW + 3;

  logic [SW-1:0]     vld_r;
  vpr_pkg::item_t    item_r [SW];
  logic [2*SW-1:0]   rad_r  [SW];
  logic [RW-1:0]     rem_r  [SW];
  logic [SW-1:0]     root_r [SW];

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic            vld_in;
    vpr_pkg::item_t  item_in;
    logic [2*SW-1:0] rad_in;
    logic [RW-1:0]   rem_in;
    logic [SW-1:0]   root_in;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nxt;
    logic [SW-1:0]   root_nxt;

    if (k == 0) begin : g_head
      // radicand is dot(b,b) scaled by two fraction widths
      assign vld_in  = in_vld;
      assign item_in = in_item;
      assign rad_in  = (2*SW)'({in_item.dbb, {(2*vpr_pkg::FRAC_BITS){1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign item_in = item_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[RW-3:0], rad_in[2*SW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[SW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[SW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      item_r[k] <= item_in;
      rad_r[k]  <= rad_in << 2;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
    end
  end

  assign out_vld  = vld_r[SW-1];
  assign out_item = item_r[SW-1];
  assign out_root = root_r[SW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vpr_div4.sv =====
`default_nettype none

module vpr_div4 (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_vld,
  input  vpr_pkg::side_t                                in_side,
  input  logic [3:0][vpr_pkg::NUM_W-1:0]                in_num,
  input  logic [3:0]                                    in_neg,
  input  logic [vpr_pkg::DIV_W-1:0]                     in_den,
  output logic                                          out_vld,
  output vpr_pkg::side_t                                out_side,
  output logic [3:0][vpr_pkg::COMP_WIDTH-1:0]           out_q,
  output logic [3:0]                                    out_ov,
  output logic [3:0]                                    out_neg
);

  localparam int CW = vpr_pkg::COMP_WIDTH;
  localparam int RW = vpr_pkg::REM_W;
  localparam int DW = vpr_pkg::DIV_W;
  localparam int NS = CW + 1;

  logic [NS-1:0]        vld_r;
  vpr_pkg::side_t       side_r [NS];
  logic [DW-1:0]        den_r  [NS];
  logic [3:0]           neg_r  [NS];
  logic [3:0]           ov_r   [NS];
  logic [3:0][RW-1:0]   rem_r  [NS];
  logic [3:0][CW-1:0]   q_r    [NS];

  // stage 0 flags quotients that do not fit, then one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic               vld_in;
    vpr_pkg::side_t     side_in;
    logic [DW-1:0]      den_in;
    logic [3:0]         neg_in;
    logic [3:0]         ov_in;
    logic [3:0][RW-1:0] rem_in;
    logic [3:0][CW-1:0] q_in;
    logic [3:0]         ov_nxt;
    logic [3:0][RW-1:0] rem_nxt;
    logic [3:0][CW-1:0] q_nxt;
    logic [RW-1:0]      dsh;

    if (k == 0) begin : g_head
      assign vld_in  = in_vld;
      assign side_in = in_side;
      assign den_in  = in_den;
      assign neg_in  = in_neg;
      assign ov_in   = '0;
      assign q_in    = '0;
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = RW'(in_num[l]);
      end

      // quotient overflow check against the divisor shifted past all bits
      always_comb begin
        dsh     = RW'(den_in) << CW;
        rem_nxt = rem_in;
        q_nxt   = q_in;
        for (int l = 0; l < 4; l++) begin
          ov_nxt[l] = ov_in[l] | (rem_in[l] >= dsh);
        end
      end
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign side_in = side_r[k-1];
      assign den_in  = den_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign ov_in   = ov_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];

      // restoring step for quotient bit CW-k
      always_comb begin
        dsh    = RW'(den_in) << (CW - k);
        ov_nxt = ov_in;
        for (int l = 0; l < 4; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_nxt[l] = rem_in[l] - dsh;
            q_nxt[l]   = {q_in[l][CW-2:0], 1'b1};
          end else begin
            rem_nxt[l] = rem_in[l];
            q_nxt[l]   = {q_in[l][CW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      den_r[k]  <= den_in;
      neg_r[k]  <= neg_in;
      ov_r[k]   <= ov_nxt;
      rem_r[k]  <= rem_nxt;
      q_r[k]    <= q_nxt;
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
  assign out_q    = q_r[NS-1];
  assign out_ov   = ov_r[NS-1];
  assign out_neg  = neg_r[NS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vector4_project_reject_normalize_core.sv =====
// a Q16.16 request passes stages 0-1, square root, stages 2-7, divider and output register
// throughput: one request per cycle, set by the root and divider pipelines (one bit a stage)
// busy is high only while rst_n is low; the result strobe cannot be stalled
// reset: synchronous active-low rst_n clears every pipeline valid bit, payload is not reset
`default_nettype none

module vector4_project_reject_normalize_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_action,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_a_x,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_a_y,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_a_z,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_a_w,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_b_x,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_b_y,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_b_z,
  input  logic signed [vpr_pkg::COMP_WIDTH-1:0]  in_b_w,
  output logic                                   out_valid,
  output logic signed [vpr_pkg::COMP_WIDTH-1:0]  out_r_x,
  output logic signed [vpr_pkg::COMP_WIDTH-1:0]  out_r_y,
  output logic signed [vpr_pkg::COMP_WIDTH-1:0]  out_r_z,
  output logic signed [vpr_pkg::COMP_WIDTH-1:0]  out_r_w,
  output logic                                   out_degenerate,
  output logic                                   out_saturated
);

  localparam int CW  = vpr_pkg::COMP_WIDTH;
  localparam int FB  = vpr_pkg::FRAC_BITS;
  localparam int DT  = vpr_pkg::DOT_W;
  localparam int SW  = vpr_pkg::SQ_W;
  localparam int MW  = vpr_pkg::MAG_W;
  localparam int NW  = vpr_pkg::NUM_W;
  localparam int DW  = vpr_pkg::DIV_W;
  localparam int CH  = vpr_pkg::CHUNK_W;
  localparam int PW  = CW + CH;

  // no backpressure: requests are only refused during reset
  assign busy = ~rst_n;

  // stage 0: component products (normalize squares a)
  vpr_pkg::comp_t [3:0]  a_in;
  vpr_pkg::comp_t [3:0]  b_in;
  logic [3:0][2*CW-1:0]  pab_nxt;
  logic [3:0][2*CW-1:0]  pbb_nxt;

  always_comb begin
    a_in = {in_a_w, in_a_z, in_a_y, in_a_x};
    if (in_action == vpr_pkg::ACT_NORMALIZE) begin
      b_in = a_in;
    end else begin
      b_in = {in_b_w, in_b_z, in_b_y, in_b_x};
    end
    for (int i = 0; i < 4; i++) begin
      pab_nxt[i] = (2*CW)'($signed(a_in[i])) * (2*CW)'($signed(b_in[i]));
      pbb_nxt[i] = (2*CW)'($signed(b_in[i])) * (2*CW)'($signed(b_in[i]));
    end
  end

  logic                  s0_vld_r;
  logic [1:0]            s0_act_r;
  vpr_pkg::comp_t [3:0]  s0_a_r;
  vpr_pkg::comp_t [3:0]  s0_b_r;
  logic [3:0][2*CW-1:0]  s0_pab_r;
  logic [3:0][2*CW-1:0]  s0_pbb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_act_r <= in_action;
    s0_a_r   <= a_in;
    s0_b_r   <= b_in;
    s0_pab_r <= pab_nxt;
    s0_pbb_r <= pbb_nxt;
  end

  // stage 1: dot product sums
  logic signed [DT:0] dab_nxt;
  logic signed [DT:0] dbb_sum;

  always_comb begin
    dab_nxt = '0;
    dbb_sum = '0;
    for (int i = 0; i < 4; i++) begin
      dab_nxt = dab_nxt + (DT+1)'($signed(s0_pab_r[i]));
      dbb_sum = dbb_sum + (DT+1)'($signed(s0_pbb_r[i]));
    end
  end

  logic           s1_vld_r;
  vpr_pkg::item_t s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r.act <= s0_act_r;
    s1_item_r.a   <= s0_a_r;
    s1_item_r.b   <= s0_b_r;
    s1_item_r.dab <= dab_nxt;
    s1_item_r.dbb <= dbb_sum[DT-1:0];
  end

  // square root of the scaled dot product, every request passes through
  logic           sq_vld;
  vpr_pkg::item_t sq_item;
  logic [SW-1:0]  sq_root;

  vpr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld_r),
    .in_item  (s1_item_r),
    .out_vld  (sq_vld),
    .out_item (sq_item),
    .out_root (sq_root)
  );

  // stage 2: magnitudes and signs
  vpr_pkg::comp_t [3:0] amag_nxt;
  vpr_pkg::comp_t [3:0] bmag_nxt;
  vpr_pkg::comp_t [3:0] aneg;
  vpr_pkg::comp_t [3:0] bneg;
  logic [3:0]           asgn_nxt;
  logic [3:0]           nsgn_nxt;
  logic [DT:0]          dneg;
  logic [DT-1:0]        dmag_nxt;

  always_comb begin
    dneg     = -sq_item.dab;
    dmag_nxt = sq_item.dab[DT] ? dneg[DT-1:0] : sq_item.dab[DT-1:0];
    for (int i = 0; i < 4; i++) begin
      aneg[i]     = -sq_item.a[i];
      bneg[i]     = -sq_item.b[i];
      amag_nxt[i] = sq_item.a[i][CW-1] ? aneg[i] : sq_item.a[i];
      bmag_nxt[i] = sq_item.b[i][CW-1] ? bneg[i] : sq_item.b[i];
      asgn_nxt[i] = sq_item.a[i][CW-1];
      nsgn_nxt[i] = sq_item.b[i][CW-1] ^ sq_item.dab[DT];
    end
  end

  logic                 s2_vld_r;
  logic [1:0]           s2_act_r;
  vpr_pkg::comp_t [3:0] s2_amag_r;
  vpr_pkg::comp_t [3:0] s2_bmag_r;
  logic [3:0]           s2_asgn_r;
  logic [3:0]           s2_nsgn_r;
  logic [DT-1:0]        s2_dmag_r;
  logic [DT-1:0]        s2_dbb_r;
  logic [SW-1:0]        s2_root_r;
  logic                 s2_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_act_r  <= sq_item.act;
    s2_amag_r <= amag_nxt;
    s2_bmag_r <= bmag_nxt;
    s2_asgn_r <= asgn_nxt;
    s2_nsgn_r <= nsgn_nxt;
    s2_dmag_r <= dmag_nxt;
    s2_dbb_r  <= sq_item.dbb;
    s2_root_r <= sq_root;
    s2_deg_r  <= (sq_item.dbb == '0);
  end

  // stage 3: sliced partial products a*dot(b,b) and b*dot(a,b)
  logic [3*CH-1:0]          dbb_pad;
  logic [3*CH-1:0]          dab_pad;
  logic [3:0][2:0][PW-1:0]  pa_nxt;
  logic [3:0][2:0][PW-1:0]  pb_nxt;

  always_comb begin
    dbb_pad = (3*CH)'(s2_dbb_r);
    dab_pad = (3*CH)'(s2_dmag_r);
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 3; c++) begin
        pa_nxt[i][c] = PW'(s2_amag_r[i]) * PW'(dbb_pad[c*CH +: CH]);
        pb_nxt[i][c] = PW'(s2_bmag_r[i]) * PW'(dab_pad[c*CH +: CH]);
      end
    end
  end

  logic                     s3_vld_r;
  logic [1:0]               s3_act_r;
  vpr_pkg::comp_t [3:0]     s3_amag_r;
  logic [3:0]               s3_asgn_r;
  logic [3:0]               s3_nsgn_r;
  logic [DT-1:0]            s3_dbb_r;
  logic [SW-1:0]            s3_root_r;
  logic                     s3_deg_r;
  logic [3:0][2:0][PW-1:0]  s3_pa_r;
  logic [3:0][2:0][PW-1:0]  s3_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_act_r  <= s2_act_r;
    s3_amag_r <= s2_amag_r;
    s3_asgn_r <= s2_asgn_r;
    s3_nsgn_r <= s2_nsgn_r;
    s3_dbb_r  <= s2_dbb_r;
    s3_root_r <= s2_root_r;
    s3_deg_r  <= s2_deg_r;
    s3_pa_r   <= pa_nxt;
    s3_pb_r   <= pb_nxt;
  end

  // stage 4: recombine the slices
  logic [3:0][MW-1:0] m1_nxt;
  logic [3:0][MW-1:0] m2_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m1_nxt[i] = '0;
      m2_nxt[i] = '0;
      for (int c = 0; c < 3; c++) begin
        m1_nxt[i] = m1_nxt[i] + (MW'(s3_pa_r[i][c]) << (c*CH));
        m2_nxt[i] = m2_nxt[i] + (MW'(s3_pb_r[i][c]) << (c*CH));
      end
    end
  end

  logic                 s4_vld_r;
  logic [1:0]           s4_act_r;
  vpr_pkg::comp_t [3:0] s4_amag_r;
  logic [3:0]           s4_asgn_r;
  logic [3:0]           s4_nsgn_r;
  logic [DT-1:0]        s4_dbb_r;
  logic [SW-1:0]        s4_root_r;
  logic                 s4_deg_r;
  logic [3:0][MW-1:0]   s4_m1_r;
  logic [3:0][MW-1:0]   s4_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_act_r  <= s3_act_r;
    s4_amag_r <= s3_amag_r;
    s4_asgn_r <= s3_asgn_r;
    s4_nsgn_r <= s3_nsgn_r;
    s4_dbb_r  <= s3_dbb_r;
    s4_root_r <= s3_root_r;
    s4_deg_r  <= s3_deg_r;
    s4_m1_r   <= m1_nxt;
    s4_m2_r   <= m2_nxt;
  end

  // stage 5: apply signs
  logic [3:0][MW:0] sv1_nxt;
  logic [3:0][MW:0] sv2_nxt;
  logic [3:0][MW:0] m1x;
  logic [3:0][MW:0] m2x;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m1x[i]     = (MW+1)'(s4_m1_r[i]);
      m2x[i]     = (MW+1)'(s4_m2_r[i]);
      sv1_nxt[i] = s4_asgn_r[i] ? -m1x[i] : m1x[i];
      sv2_nxt[i] = s4_nsgn_r[i] ? -m2x[i] : m2x[i];
    end
  end

  logic                 s5_vld_r;
  logic [1:0]           s5_act_r;
  vpr_pkg::comp_t [3:0] s5_amag_r;
  logic [3:0]           s5_asgn_r;
  logic [DT-1:0]        s5_dbb_r;
  logic [SW-1:0]        s5_root_r;
  logic                 s5_deg_r;
  logic [3:0][MW:0]     s5_sv1_r;
  logic [3:0][MW:0]     s5_sv2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_act_r  <= s4_act_r;
    s5_amag_r <= s4_amag_r;
    s5_asgn_r <= s4_asgn_r;
    s5_dbb_r  <= s4_dbb_r;
    s5_root_r <= s4_root_r;
    s5_deg_r  <= s4_deg_r;
    s5_sv1_r  <= sv1_nxt;
    s5_sv2_r  <= sv2_nxt;
  end

  // stage 6: signed numerator, reject subtracts the projection
  logic [3:0][MW+1:0] num_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s5_act_r == vpr_pkg::ACT_REJECT) begin
        num_nxt[i] = (MW+2)'($signed(s5_sv1_r[i])) - (MW+2)'($signed(s5_sv2_r[i]));
      end else begin
        num_nxt[i] = (MW+2)'($signed(s5_sv2_r[i]));
      end
    end
  end

  logic                 s6_vld_r;
  logic [1:0]           s6_act_r;
  vpr_pkg::comp_t [3:0] s6_amag_r;
  logic [3:0]           s6_asgn_r;
  logic [DT-1:0]        s6_dbb_r;
  logic [SW-1:0]        s6_root_r;
  logic                 s6_deg_r;
  logic [3:0][MW+1:0]   s6_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_act_r  <= s5_act_r;
    s6_amag_r <= s5_amag_r;
    s6_asgn_r <= s5_asgn_r;
    s6_dbb_r  <= s5_dbb_r;
    s6_root_r <= s5_root_r;
    s6_deg_r  <= s5_deg_r;
    s6_num_r  <= num_nxt;
  end

  // stage 7: divider operands in magnitude and sign form
  logic [3:0][MW+1:0] numneg;
  logic [3:0][NW-1:0] nmag_nxt;
  logic [3:0]         nsg_nxt;
  logic [DW-1:0]      den_nxt;
  vpr_pkg::side_t     side_nxt;

  always_comb begin
    side_nxt.act = s6_act_r;
    side_nxt.deg = s6_deg_r;
    if (s6_deg_r) begin
      den_nxt = DW'(1);
    end else if (s6_act_r == vpr_pkg::ACT_NORMALIZE) begin
      den_nxt = DW'(s6_root_r);
    end else begin
      den_nxt = s6_dbb_r;
    end
    for (int i = 0; i < 4; i++) begin
      numneg[i] = -s6_num_r[i];
      if (s6_act_r == vpr_pkg::ACT_NORMALIZE) begin
        nmag_nxt[i] = NW'({s6_amag_r[i], {(2*FB){1'b0}}});
        nsg_nxt[i]  = s6_asgn_r[i];
      end else if (s6_num_r[i][MW+1]) begin
        nmag_nxt[i] = NW'(numneg[i][MW-1:0]);
        nsg_nxt[i]  = 1'b1;
      end else begin
        nmag_nxt[i] = NW'(s6_num_r[i][MW-1:0]);
        nsg_nxt[i]  = 1'b0;
      end
    end
  end

  logic               s7_vld_r;
  vpr_pkg::side_t     s7_side_r;
  logic [3:0][NW-1:0] s7_nmag_r;
  logic [3:0]         s7_nsg_r;
  logic [DW-1:0]      s7_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_side_r <= side_nxt;
    s7_nmag_r <= nmag_nxt;
    s7_nsg_r  <= nsg_nxt;
    s7_den_r  <= den_nxt;
  end

  // four-lane pipelined divider
  logic               dv_vld;
  vpr_pkg::side_t     dv_side;
  logic [3:0][CW-1:0] dv_q;
  logic [3:0]         dv_ov;
  logic [3:0]         dv_neg;

  vpr_div4 u_div4 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s7_vld_r),
    .in_side  (s7_side_r),
    .in_num   (s7_nmag_r),
    .in_neg   (s7_nsg_r),
    .in_den   (s7_den_r),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_q    (dv_q),
    .out_ov   (dv_ov),
    .out_neg  (dv_neg)
  );

  // output stage: sign, saturation and special cases
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic               act_ok;
  logic [3:0]         ng;
  logic [3:0]         over;
  logic [3:0][CW-1:0] lim;
  logic [3:0][CW-1:0] qneg;
  logic [3:0][CW-1:0] r_nxt;
  logic               deg_nxt;
  logic               sat_nxt;

  always_comb begin
    act_ok = (dv_side.act == vpr_pkg::ACT_PROJECT) || (dv_side.act == vpr_pkg::ACT_REJECT)
          || (dv_side.act == vpr_pkg::ACT_NORMALIZE);
    for (int l = 0; l < 4; l++) begin
      ng[l]   = dv_neg[l] & ((dv_q[l] != '0) | dv_ov[l]);
      lim[l]  = ng[l] ? MINV : MAXV;
      over[l] = dv_ov[l] | (dv_q[l] > lim[l]);
      qneg[l] = -dv_q[l];
      if (!act_ok || dv_side.deg) begin
        r_nxt[l] = '0;
      end else if (over[l]) begin
        r_nxt[l] = lim[l];
      end else begin
        r_nxt[l] = ng[l] ? qneg[l] : dv_q[l];
      end
    end
    deg_nxt = act_ok & dv_side.deg;
    sat_nxt = act_ok & ~dv_side.deg & (|over);
  end

  logic               out_vld_r;
  logic [3:0][CW-1:0] out_r_r;
  logic               out_deg_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r_r   <= r_nxt;
    out_deg_r <= deg_nxt;
    out_sat_r <= sat_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_r_x        = out_r_r[0];
  assign out_r_y        = out_r_r[1];
  assign out_r_z        = out_r_r[2];
  assign out_r_w        = out_r_r[3];
  assign out_degenerate = out_deg_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vpr_checker.sv =====
`default_nettype none

module vpr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic signed [vpr_pkg::COMP_WIDTH-1:0] out_r_x,
  input logic signed [vpr_pkg::COMP_WIDTH-1:0] out_r_y,
  input logic signed [vpr_pkg::COMP_WIDTH-1:0] out_r_z,
  input logic signed [vpr_pkg::COMP_WIDTH-1:0] out_r_w,
  input logic                                  out_degenerate,
  input logic                                  out_saturated
);

  localparam int LAT = vpr_pkg::LATENCY;
  localparam logic [vpr_pkg::COMP_WIDTH-1:0] MAXV = {1'b0, {(vpr_pkg::COMP_WIDTH-1){1'b1}}};
  localparam logic [vpr_pkg::COMP_WIDTH-1:0] MINV = {1'b1, {(vpr_pkg::COMP_WIDTH-1){1'b0}}};

  // every accepted request yields its result after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request produced no result at the expected cycle");

  // no result appears without a request the fixed latency earlier
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  // a zero divisor gives a zero vector and no clamp
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_w == '0 && !out_saturated))
    else $error("degenerate result is not a clean zero vector");

  // a clamp leaves at least one component at a range limit
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_r_x == MAXV || out_r_x == MINV || out_r_y == MAXV || out_r_y == MINV ||
       out_r_z == MAXV || out_r_z == MINV || out_r_w == MAXV || out_r_w == MINV))
    else $error("saturated flag set with no component at a limit");

endmodule

bind vector4_project_reject_normalize_core vpr_checker u_vpr_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // action code the block leaves unused, answered with a zero vector
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int         RANDOM_ITEMS = 1730;
  localparam int         WATCHDOG_LIMIT = 4 * (vpr_pkg::LATENCY + 20);

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [1:0]     act;
    vpr_pkg::comp_t a[4];
    vpr_pkg::comp_t b[4];
    bit             drain;
  } vec_req_t;

  typedef struct {
    vpr_pkg::comp_t r[4];
    logic           deg;
    logic           sat;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  vpr_pkg::comp_t in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  vpr_pkg::comp_t in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic out_valid;
  vpr_pkg::comp_t out_r_x, out_r_y, out_r_z, out_r_w;
  logic out_degenerate, out_saturated;

  vec_req_t pending_reqs[$];
  vec_res_t expected_vecs[$];
  logic     taken = 1'b0;
  int       gap_left = 0;
  bit       burst = 1'b0;
  bit       stim_done = 1'b0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_deg = 0;
  int       n_sat = 0;
  int       n_act[4] = '{0, 0, 0, 0};

  vector4_project_reject_normalize_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_degenerate(out_degenerate), .out_saturated(out_saturated)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor square root of a non-negative value below 2^191
  function automatic wide_t isqrt(wide_t n);
    logic [191:0] res, t;
    res = '0;
    for (int i = 95; i >= 0; i--) begin
      t = res | (192'd1 << i);
      if (t * t <= n) res = t;
    end
    return wide_t'(res);
  endfunction

  // expected projection, rejection or normalisation of one request
  function automatic vec_res_t vec_predict(vec_req_t q);
    vec_res_t res;
    wide_t av[4], bv[4], dab, dbb, dd, num, quo, root;
    wide_t hi, lo;
    hi = wide_t'(32'sh7fffffff);
    lo = -wide_t'(33'sh080000000);
    res.deg = 1'b0;
    res.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res.r[i] = '0;
      av[i] = wide_t'($signed(q.a[i]));
      bv[i] = wide_t'($signed(q.b[i]));
    end
    dab = 0;
    dbb = 0;
    dd = 0;
    for (int i = 0; i < 4; i++) begin
      dab += av[i] * bv[i];
      dbb += bv[i] * bv[i];
      dd += av[i] * av[i];
    end
    if (q.act == ACT_SPARE) return res;
    if (q.act == vpr_pkg::ACT_NORMALIZE) begin
      if (dd == 0) begin
        res.deg = 1'b1;
        return res;
      end
      root = isqrt(dd <<< (2 * vpr_pkg::FRAC_BITS));
    end else if (dbb == 0) begin
      res.deg = 1'b1;
      return res;
    end
    for (int i = 0; i < 4; i++) begin
      case (q.act)
        vpr_pkg::ACT_PROJECT: quo = (bv[i] * dab) / dbb;
        vpr_pkg::ACT_REJECT: begin
          num = av[i] * dbb - bv[i] * dab;
          quo = num / dbb;
        end
        default:       quo = (av[i] <<< (2 * vpr_pkg::FRAC_BITS)) / root;
      endcase
      if (quo > hi) begin
        quo = hi;
        res.sat = 1'b1;
      end else if (quo < lo) begin
        quo = lo;
        res.sat = 1'b1;
      end
      res.r[i] = quo[vpr_pkg::COMP_WIDTH-1:0];
    end
    return res;
  endfunction

  // one random component, mostly moderate so results stay in range
  function automatic vpr_pkg::comp_t rand_comp();
    case ($urandom_range(0, 9))
      0:       return vpr_pkg::comp_t'($urandom);
      1:       return '0;
      2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3, 4:    return vpr_pkg::comp_t'($signed($urandom_range(0, 2047)) - 1024);
      default: return vpr_pkg::comp_t'($signed($urandom_range(0, 32'h0007ffff))
                                       - 32'sh00040000);
    endcase
  endfunction

  function automatic vec_req_t mk_req(logic [1:0] act, vpr_pkg::comp_t ax,
                                      vpr_pkg::comp_t ay, vpr_pkg::comp_t az,
                                      vpr_pkg::comp_t aw, vpr_pkg::comp_t bx,
                                      vpr_pkg::comp_t by, vpr_pkg::comp_t bz,
                                      vpr_pkg::comp_t bw);
    vec_req_t q;
    q.act = act;
    q.a = '{ax, ay, az, aw};
    q.b = '{bx, by, bz, bw};
    q.drain = 1'b0;
    return q;
  endfunction

  // stimulus: directed corners then random requests
  initial begin
    vec_req_t q;
    int roll;
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_PROJECT, 32'h10000, 0, 0, 0,
                                  32'h10000, 32'h10000, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_REJECT, 32'h10000, 0, 0, 0,
                                  32'h10000, 32'h10000, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_NORMALIZE, 32'h30000, 32'h40000, 0, 0,
                                  0, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_PROJECT, 1, 2, 3, 4, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_REJECT, 1, 2, 3, 4, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_NORMALIZE, 0, 0, 0, 0, 5, 6, 7, 8));
    pending_reqs.push_back(mk_req(ACT_SPARE, 32'h7fffffff, 32'h80000000, 5, 6,
                                  32'hffffffff, 32'h7fffffff, 7, 8));
    for (int k = 0; k < 3; k++) begin
      pending_reqs.push_back(mk_req(2'(k), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h7fffffff, 1, 1, 1, 1));
      pending_reqs.push_back(mk_req(2'(k), 32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h7fffffff, 1, 32'hffffffff));
      pending_reqs.push_back(mk_req(2'(k), 32'hffffffff, 32'h1, 32'h80000000,
                                    32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000));
    end
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_NORMALIZE, 32'h80000000, 0, 0, 0,
                                  0, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_PROJECT, 32'h7fffffff, 0, 0, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_REJECT, 32'h7fffffff, 0, 0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(mk_req(vpr_pkg::ACT_PROJECT, 32'h10000, 32'h10000, 32'h10000,
                                  32'h10000, 32'hffff0000, 32'h00010000, 32'hffff0000,
                                  32'h00010000));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 19);
      q.act = (roll == 0) ? ACT_SPARE : 2'($urandom_range(0, 2));
      for (int i = 0; i < 4; i++) begin
        q.a[i] = rand_comp();
        q.b[i] = (roll == 1) ? vpr_pkg::comp_t'(0) : rand_comp();
      end
      // full-width bit patterns now and then
      if (roll == 2) begin
        for (int i = 0; i < 4; i++) begin
          q.a[i] = vpr_pkg::comp_t'($urandom);
          q.b[i] = vpr_pkg::comp_t'($urandom);
        end
      end
      q.drain = (n == RANDOM_ITEMS / 2);
      pending_reqs.push_back(q);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_vecs.size() == 0);
    repeat (vpr_pkg::LATENCY + 20) @(posedge clk);
    stim_done = 1'b1;
    $display("covered %0d requests: project %0d, reject %0d, normalize %0d, unused code %0d",
             n_sent, n_act[0], n_act[1], n_act[2], n_act[3]);
    $display("checked %0d results, %0d degenerate, %0d saturated",
             n_checked, n_deg, n_sat);
    if (errors == 0 && expected_vecs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // driver: presents requests at the falling edge with random gaps
  always @(negedge clk) begin
    vec_req_t q;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_reqs.size() > 0 &&
                 (!pending_reqs[0].drain || expected_vecs.size() == 0)) begin
      q = pending_reqs.pop_front();
      in_action <= q.act;
      in_a_x <= q.a[0];
      in_a_y <= q.a[1];
      in_a_z <= q.a[2];
      in_a_w <= q.a[3];
      in_b_x <= q.b[0];
      in_b_y <= q.b[1];
      in_b_z <= q.b[2];
      in_b_w <= q.b[3];
      start <= 1'b1;
      if ((n_sent % 150) == 0) burst = $urandom_range(0, 2) == 0;
      gap_left <= burst ? 0 : $urandom_range(0, 17);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predicts on each accepted request, checks each result strobe
  always @(posedge clk) begin
    vec_req_t q;
    vec_res_t got, want;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      q = mk_req(in_action, in_a_x, in_a_y, in_a_z, in_a_w, in_b_x, in_b_y, in_b_z, in_b_w);
      expected_vecs.push_back(vec_predict(q));
      n_act[in_action]++;
      n_sent++;
    end
    if (rst_n && out_valid) begin
      got.r = '{out_r_x, out_r_y, out_r_z, out_r_w};
      got.deg = out_degenerate;
      got.sat = out_saturated;
      if (expected_vecs.size() == 0) begin
        $display("%0t: result with no request outstanding: r=%h %h %h %h", $time,
                 got.r[0], got.r[1], got.r[2], got.r[3]);
        errors++;
      end else begin
        want = expected_vecs.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.r[i] !== want.r[i]) begin
            $display("%0t: r[%0d] expected %h actual %h", $time, i, want.r[i], got.r[i]);
            errors++;
          end
        end
        if (got.deg !== want.deg) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.deg, got.deg);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          errors++;
        end
        n_checked++;
        if (want.deg) n_deg++;
        if (want.sat) n_sat++;
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || stim_done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
